>>> rtl/read_flag_statistics_assert.svh
// ---------------------------------------------------------------------------
// Read flag statistics: assertion macros
// Shared property forms for the checker of the read flag statistics block.
// ---------------------------------------------------------------------------
`ifndef READ_FLAG_STATISTICS_ASSERT_SVH
`define READ_FLAG_STATISTICS_ASSERT_SVH

// same-cycle implication, disabled during reset
`define RFS_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("read flag statistics: same-cycle check failed");

// next-cycle implication, disabled while rst is high
`define RFS_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("read flag statistics: next-cycle check failed");

`endif

>>> rtl/rfs_pkg.sv
// ---------------------------------------------------------------------------
// Read flag statistics package
// Field widths, request and counter codes, and the item types that pass
// between the front end, the queues and the back end.
// ---------------------------------------------------------------------------
package rfs_pkg;

   localparam int NUM_EVENTS = 12;
   localparam int VALUE_W    = 48;
   localparam int SUM_W      = 48;
   localparam int BIN_DATA_W = 32;
   localparam int INSERT_W   = 32;
   localparam int LEN_W      = 16;
   localparam int FLAG_W     = 11;
   localparam int QIDX_W     = 10;
   localparam int SEL_W      = 4;

   // request codes
   typedef enum logic [1:0] {
      OP_RECORD  = 2'd0,
      OP_COUNTER = 2'd1,
      OP_BIN     = 2'd2,
      OP_NONE    = 2'd3
   } op_type;

   // counter numbers past the event counters
   localparam logic [SEL_W-1:0] SEL_INSERT_SUM   = 4'd12;
   localparam logic [SEL_W-1:0] SEL_INSERT_COUNT = 4'd13;

   // event counter numbers
   localparam int EV_READS    = 0;
   localparam int EV_DUP      = 1;
   localparam int EV_QCFAIL   = 2;
   localparam int EV_MAPPED   = 3;
   localparam int EV_FORWARD  = 4;
   localparam int EV_REVERSE  = 5;
   localparam int EV_PAIRED   = 6;
   localparam int EV_FIRST    = 7;
   localparam int EV_SECOND   = 8;
   localparam int EV_BOTH     = 9;
   localparam int EV_SINGLE   = 10;
   localparam int EV_PROPER   = 11;

   // flag word bit positions
   localparam int FL_PAIRED        = 0;
   localparam int FL_PROPER        = 1;
   localparam int FL_UNMAPPED      = 2;
   localparam int FL_MATE_UNMAPPED = 3;
   localparam int FL_REVERSE       = 4;
   localparam int FL_FIRST         = 6;
   localparam int FL_SECOND        = 7;
   localparam int FL_QCFAIL        = 9;
   localparam int FL_DUP           = 10;

   // classified item, front end to back end
   typedef struct packed {
      op_type                  op;
      logic [NUM_EVENTS-1:0]   events;
      logic                    ins_ok;
      logic [INSERT_W-1:0]     ins_mag;
      logic [LEN_W-1:0]        bin;
      logic [SEL_W-1:0]        sel;
      logic                    index_bad;
   } cmd_type;

   // result item
   typedef struct packed {
      logic [VALUE_W-1:0]      value;
      logic                    index_bad;
   } rsp_type;

   // back end control toward the queues and the front end
   typedef struct packed {
      logic cmd_pop;
      logic rsp_push;
      logic clearing;
   } back_ctl_type;

endpackage

>>> rtl/read_flag_statistics.sv
// ---------------------------------------------------------------------------
// Read flag statistics
// One request item per read record or query. Records bump the flag
// counters, the insert sum and count, and one length histogram bin;
// queries return a counter, the insert sum or count, or a bin.
//
// Channels: req_* in, rsp_* out, both valid/stall; an item moves on an
// edge with valid high and stall low. csr_write_enable/csr_write_data
// write insert_enable; write it only while the block is idle.
// Throughput: one item per cycle in both directions, sustained while
// rsp_stall stays low and no clearing pass runs. A request enters the
// request queue, issues with its histogram read into stage 2, and is
// pushed into the result queue, whose head drives rsp_valid. The histogram
// memory's single registered read port sets the two-stage back end.
// Reset: counters and sums clear at once; then a clearing pass writes the
// histogram one bin per cycle, with req_stall high.
// Stall: a stalled result holds; the 4-entry result queue and 4-entry
// request queue fill, then req_stall rises.
// ---------------------------------------------------------------------------
module read_flag_statistics #(
   parameter int LENGTH_BINS   = 1024,
   parameter int COUNTER_WIDTH = 40
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_type,
   input  logic [10:0]                         req_flag_word,
   input  logic [15:0]                         req_read_length,
   input  logic signed [31:0]                  req_insert_size,
   input  logic [9:0]                          req_query_index,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [47:0]                         rsp_value,
   output logic                                rsp_index_bad,
   input  logic                                csr_write_enable,
   input  logic                                csr_write_data
);

   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 4;
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);
   localparam int CMD_W     = $bits(rfs_pkg::cmd_type);
   localparam int RSP_W     = $bits(rfs_pkg::rsp_type);

   logic                          cmd_push;
   rfs_pkg::cmd_type              cmd_in;
   logic                          cmd_valid;
   logic [CMD_W-1:0]              cmd_head_bits;
   rfs_pkg::cmd_type              cmd_head;
   logic [CMD_CNT_W-1:0]          cmd_count;
   logic                          cmd_full;
   rfs_pkg::back_ctl_type         back_ctl;
   rfs_pkg::rsp_type              rsp_in;
   logic [RSP_W-1:0]              rsp_head_bits;
   rfs_pkg::rsp_type              rsp_head;
   logic [RSP_CNT_W-1:0]          rsp_count;
   logic                          rsp_pop;

   assign cmd_full = (cmd_count == CMD_CNT_W'(CMD_DEPTH));

   // front end: accept and classify
   rfs_front #(
      .LENGTH_BINS (LENGTH_BINS)
   ) u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_flag_word   (req_flag_word),
      .req_read_length (req_read_length),
      .req_insert_size (req_insert_size),
      .req_query_index (req_query_index),
      .queue_full      (cmd_full),
      .clearing        (back_ctl.clearing),
      .push            (cmd_push),
      .cmd             (cmd_in)
   );

   // classified items between front and back
   rfs_queue #(
      .DATA_WIDTH (CMD_W),
      .DEPTH      (CMD_DEPTH)
   ) u_cmd_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_data  (cmd_in),
      .pop        (back_ctl.cmd_pop),
      .head_valid (cmd_valid),
      .head_data  (cmd_head_bits),
      .count      (cmd_count)
   );

   assign cmd_head = cmd_head_bits;

   // back end: counters and histogram
   rfs_back #(
      .LENGTH_BINS   (LENGTH_BINS),
      .COUNTER_WIDTH (COUNTER_WIDTH),
      .RSP_DEPTH     (RSP_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg_we    (csr_write_enable),
      .cfg_data  (csr_write_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd_head),
      .rsp_count (rsp_count),
      .ctl       (back_ctl),
      .rsp       (rsp_in)
   );

   // result queue toward the receiver
   assign rsp_pop = rsp_valid && !rsp_stall;

   rfs_queue #(
      .DATA_WIDTH (RSP_W),
      .DEPTH      (RSP_DEPTH)
   ) u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (back_ctl.rsp_push),
      .push_data  (rsp_in),
      .pop        (rsp_pop),
      .head_valid (rsp_valid),
      .head_data  (rsp_head_bits),
      .count      (rsp_count)
   );

   assign rsp_head      = rsp_head_bits;
   assign rsp_value     = rsp_head.value;
   assign rsp_index_bad = rsp_head.index_bad;

endmodule

>>> rtl/rfs_queue.sv
// ---------------------------------------------------------------------------
// Read flag statistics: item queue
// Small register FIFO with occupancy count. Push and pop are only issued
// when legal; the caller checks the count.
// ---------------------------------------------------------------------------
module rfs_queue #(
   parameter int DATA_WIDTH = 8,
   parameter int DEPTH      = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             push,
   input  logic [DATA_WIDTH-1:0]            push_data,
   input  logic                             pop,
   output logic                             head_valid,
   output logic [DATA_WIDTH-1:0]            head_data,
   output logic [$clog2(DEPTH+1)-1:0]       count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   logic [DATA_WIDTH-1:0] entries [DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]      count_ff,  count_in;

   // pointer and count updates
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         entries[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_data  = entries[rd_ptr_ff];
   assign count      = count_ff;

endmodule

>>> rtl/rfs_front.sv
// ---------------------------------------------------------------------------
// Read flag statistics: front end
// Accepts request items and classifies them: flag decode into event bumps,
// insert magnitude, histogram bin clamp and counter index check.
// ---------------------------------------------------------------------------
module rfs_front #(
   parameter int LENGTH_BINS = 1024
) (
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_type,
   input  logic [rfs_pkg::FLAG_W-1:0]         req_flag_word,
   input  logic [rfs_pkg::LEN_W-1:0]          req_read_length,
   input  logic signed [rfs_pkg::INSERT_W-1:0] req_insert_size,
   input  logic [rfs_pkg::QIDX_W-1:0]         req_query_index,
   input  logic                               queue_full,
   input  logic                               clearing,
   output logic                               push,
   output rfs_pkg::cmd_type                   cmd
);

   localparam logic [rfs_pkg::LEN_W-1:0] LAST_BIN = rfs_pkg::LEN_W'(LENGTH_BINS - 1);

   rfs_pkg::op_type                   op;
   logic [rfs_pkg::NUM_EVENTS-1:0]    events;
   logic [rfs_pkg::INSERT_W-1:0]      ins_bits;
   logic [rfs_pkg::LEN_W-1:0]         rec_bin;
   logic [rfs_pkg::LEN_W-1:0]         qry_bin;
   logic                              paired;
   logic                              mapped;

   // handshake
   assign req_stall = queue_full || clearing;
   assign push      = req_valid && !req_stall;

   assign op       = rfs_pkg::op_type'(req_type);
   assign ins_bits = req_insert_size;
   assign paired   = req_flag_word[rfs_pkg::FL_PAIRED];
   assign mapped   = !req_flag_word[rfs_pkg::FL_UNMAPPED];

   // flag decode; mate flags count only for paired reads
   always_comb begin
      events                       = '0;
      events[rfs_pkg::EV_READS]    = 1'b1;
      events[rfs_pkg::EV_DUP]      = req_flag_word[rfs_pkg::FL_DUP];
      events[rfs_pkg::EV_QCFAIL]   = req_flag_word[rfs_pkg::FL_QCFAIL];
      events[rfs_pkg::EV_MAPPED]   = mapped;
      events[rfs_pkg::EV_FORWARD]  = !req_flag_word[rfs_pkg::FL_REVERSE];
      events[rfs_pkg::EV_REVERSE]  = req_flag_word[rfs_pkg::FL_REVERSE];
      events[rfs_pkg::EV_PAIRED]   = paired;
      events[rfs_pkg::EV_FIRST]    = paired && req_flag_word[rfs_pkg::FL_FIRST];
      events[rfs_pkg::EV_SECOND]   = paired && req_flag_word[rfs_pkg::FL_SECOND];
      events[rfs_pkg::EV_BOTH]     = paired && mapped
                                     && !req_flag_word[rfs_pkg::FL_MATE_UNMAPPED];
      events[rfs_pkg::EV_SINGLE]   = paired && mapped
                                     && req_flag_word[rfs_pkg::FL_MATE_UNMAPPED];
      events[rfs_pkg::EV_PROPER]   = paired && req_flag_word[rfs_pkg::FL_PROPER];
   end

   // histogram bin clamps
   assign rec_bin = (req_read_length >= LAST_BIN) ? LAST_BIN : req_read_length;
   assign qry_bin = (32'(req_query_index) >= LENGTH_BINS) ? LAST_BIN
                                                          : rfs_pkg::LEN_W'(req_query_index);

   // classified item
   always_comb begin
      cmd.op        = op;
      cmd.events    = events;
      cmd.ins_ok    = paired && req_flag_word[rfs_pkg::FL_FIRST] && (ins_bits != '0);
      // most negative value gives 2^31, which fits unsigned
      cmd.ins_mag   = ins_bits[rfs_pkg::INSERT_W-1] ? (~ins_bits + 1'b1) : ins_bits;
      cmd.bin       = (op == rfs_pkg::OP_RECORD) ? rec_bin : qry_bin;
      cmd.sel       = req_query_index[rfs_pkg::SEL_W-1:0];
      cmd.index_bad = (op == rfs_pkg::OP_COUNTER)
                      && (req_query_index > rfs_pkg::QIDX_W'(rfs_pkg::SEL_INSERT_COUNT));
   end

endmodule

>>> rtl/rfs_back.sv
// ---------------------------------------------------------------------------
// Read flag statistics: back end
// Event counters, insert sum and count, and the length histogram with its
// two-stage read-modify-write. Clears the histogram after reset.
// ---------------------------------------------------------------------------
module rfs_back #(
   parameter int LENGTH_BINS   = 1024,
   parameter int COUNTER_WIDTH = 40,
   parameter int RSP_DEPTH     = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               cfg_we,
   input  logic                               cfg_data,
   input  logic                               cmd_valid,
   input  rfs_pkg::cmd_type                   cmd,
   input  logic [$clog2(RSP_DEPTH+1)-1:0]     rsp_count,
   output rfs_pkg::back_ctl_type              ctl,
   output rfs_pkg::rsp_type                   rsp
);

   localparam int BIN_W = $clog2(LENGTH_BINS);
   localparam logic [BIN_W-1:0] LAST_ADDR = BIN_W'(LENGTH_BINS - 1);
   localparam int NE = rfs_pkg::NUM_EVENTS;
   localparam int VW = rfs_pkg::VALUE_W;
   localparam int SW = rfs_pkg::SUM_W;
   localparam int DW = rfs_pkg::BIN_DATA_W;

   logic                        insert_enable_ff;
   logic [COUNTER_WIDTH-1:0]    event_ff [NE];
   logic [COUNTER_WIDTH-1:0]    event_in [NE];
   logic [SW-1:0]               sum_ff, sum_in;
   logic [SW:0]                 sum_wide;
   logic [COUNTER_WIDTH-1:0]    count_ff, count_in;

   logic                        pop;
   logic                        is_record;
   logic                        ins_do;
   logic [63:0]                 reads_ext;
   logic [63:0]                 sel_ext;
   logic [63:0]                 count_ext;
   logic [VW-1:0]               pop_value;

   logic                        s2_valid_ff;
   rfs_pkg::op_type             s2_op_ff;
   logic [VW-1:0]               s2_value_ff;
   logic                        s2_bad_ff;
   logic [BIN_W-1:0]            s2_addr_ff;

   logic [DW-1:0]               hist_mem [LENGTH_BINS];
   logic [DW-1:0]               rd_data_ff;
   logic                        wb_valid_ff;
   logic [BIN_W-1:0]            wb_addr_ff;
   logic [DW-1:0]               wb_data_ff;
   logic [DW-1:0]               hist_cur;
   logic [DW-1:0]               hist_new;
   logic                        s2_write;
   logic                        mem_we;
   logic [BIN_W-1:0]            mem_waddr;
   logic [DW-1:0]               mem_wdata;

   logic                        clear_ff;
   logic [BIN_W-1:0]            clear_addr_ff, clear_addr_in;

   // issue when the result queue has room for this item and the one in stage 2
   assign pop = cmd_valid && !clear_ff
                && ((32'(rsp_count) + 32'(s2_valid_ff)) < RSP_DEPTH);
   assign is_record = (cmd.op == rfs_pkg::OP_RECORD);
   assign ins_do    = pop && is_record && cmd.ins_ok && insert_enable_ff;

   // saturating event counters
   always_comb begin
      for (int k = 0; k < NE; k++) begin
         event_in[k] = event_ff[k];
         if (pop && is_record && cmd.events[k] && (event_ff[k] != '1)) begin
            event_in[k] = event_ff[k] + 1'b1;
         end
      end
   end

   // saturating insert sum and count
   assign sum_wide = {1'b0, sum_ff} + (SW + 1)'(cmd.ins_mag);
   always_comb begin
      sum_in   = sum_ff;
      count_in = count_ff;
      if (ins_do) begin
         sum_in = sum_wide[SW] ? '1 : sum_wide[SW-1:0];
         if (count_ff != '1) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   // counter readout, truncated or extended to the result width
   assign reads_ext = 64'(event_in[rfs_pkg::EV_READS]);
   assign sel_ext   = 64'(event_ff[cmd.sel]);
   assign count_ext = 64'(count_ff);

   always_comb begin
      pop_value = '0;
      case (cmd.op)
         rfs_pkg::OP_RECORD: begin
            pop_value = reads_ext[VW-1:0];
         end
         rfs_pkg::OP_COUNTER: begin
            if (cmd.index_bad) begin
               pop_value = '0;
            end else if (32'(cmd.sel) < NE) begin
               pop_value = sel_ext[VW-1:0];
            end else if (cmd.sel == rfs_pkg::SEL_INSERT_SUM) begin
               pop_value = VW'(sum_ff);
            end else begin
               pop_value = count_ext[VW-1:0];
            end
         end
         default: begin
            pop_value = '0;
         end
      endcase
   end

   // config register and counter state
   always_ff @(posedge clock) begin
      if (reset) begin
         insert_enable_ff <= 1'b0;
         sum_ff           <= '0;
         count_ff         <= '0;
         for (int k = 0; k < NE; k++) begin
            event_ff[k] <= '0;
         end
      end else begin
         if (cfg_we) begin
            insert_enable_ff <= cfg_data;
         end
         sum_ff   <= sum_in;
         count_ff <= count_in;
         for (int k = 0; k < NE; k++) begin
            event_ff[k] <= event_in[k];
         end
      end
   end

   // stage 2 control
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         wb_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= pop;
         wb_valid_ff <= s2_write;
      end
   end

   // stage 2 payload and last histogram write
   always_ff @(posedge clock) begin
      if (pop) begin
         s2_op_ff    <= cmd.op;
         s2_value_ff <= pop_value;
         s2_bad_ff   <= cmd.index_bad;
         s2_addr_ff  <= cmd.bin[BIN_W-1:0];
      end
      wb_addr_ff <= s2_addr_ff;
      wb_data_ff <= hist_new;
   end

   // histogram memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[mem_waddr] <= mem_wdata;
      end
      if (pop) begin
         rd_data_ff <= hist_mem[cmd.bin[BIN_W-1:0]];
      end
   end

   // bypass the write made in the same cycle as this item's read
   assign hist_cur = (wb_valid_ff && (wb_addr_ff == s2_addr_ff)) ? wb_data_ff : rd_data_ff;
   assign hist_new = (hist_cur == '1) ? hist_cur : hist_cur + 1'b1;
   assign s2_write = s2_valid_ff && (s2_op_ff == rfs_pkg::OP_RECORD);

   assign mem_we    = clear_ff || s2_write;
   assign mem_waddr = clear_ff ? clear_addr_ff : s2_addr_ff;
   assign mem_wdata = clear_ff ? '0 : hist_new;

   // clearing pass after reset
   assign clear_addr_in = clear_addr_ff + 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else if (clear_ff) begin
         clear_addr_ff <= clear_addr_in;
         if (clear_addr_ff == LAST_ADDR) begin
            clear_ff <= 1'b0;
         end
      end
   end

   // result toward the output queue
   assign rsp.value     = (s2_op_ff == rfs_pkg::OP_BIN) ? VW'(hist_cur) : s2_value_ff;
   assign rsp.index_bad = s2_bad_ff;

   assign ctl.cmd_pop  = pop;
   assign ctl.rsp_push = s2_valid_ff;
   assign ctl.clearing = clear_ff;

endmodule

>>> rtl/rfs_checker.sv
// ---------------------------------------------------------------------------
// Read flag statistics: port checker
// Watches the top-level ports over time; bound to the top level.
// ---------------------------------------------------------------------------
`include "read_flag_statistics_assert.svh"

module rfs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [47:0] rsp_value,
   input logic        rsp_index_bad
);

   logic rsp_held;

   // result offered but held off by the receiver
   assign rsp_held = rsp_valid && rsp_stall;

   // a stalled result stays offered
   `RFS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_held, rsp_valid)

   // a stalled result keeps its payload
   `RFS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_held, $stable({rsp_value, rsp_index_bad}))

   // a bad counter index returns zero
   `RFS_ASSERT_IMPLY(a_bad_zero, clock, reset, rsp_valid && rsp_index_bad, rsp_value == 48'd0)

   // after reset: no result, and requests held off for the histogram clear
   `RFS_ASSERT_NEXT(a_reset_quiet, clock, 1'b0, reset, !rsp_valid && req_stall)

endmodule

bind read_flag_statistics rfs_checker u_rfs_checker (
   .clock         (clock),
   .reset         (reset),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_value     (rsp_value),
   .rsp_index_bad (rsp_index_bad)
);

>>> verif/tb_read_flag_statistics.sv
// ---------------------------------------------------------------------------
// Read flag statistics testbench
// Drives record and query items through the valid/stall request channel,
// predicts each result not typed in the directed table from a local copy
// of counters, insert sum, count and length histogram; checks each in order.
// A directed table covers reset values, field extremes and the special
// cases; random phases follow with insert_enable toggled between them.
// ---------------------------------------------------------------------------
module tb_read_flag_statistics;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BINS          = 1024;
   localparam int CW            = 40;
   localparam int IDLE_PCT      = 15;
   localparam int SETTLE_CYCLES = 8;
   localparam int QUIET_FROM    = 550;
   localparam int QUIET_TO      = 750;
   localparam int HOLD_AT       = 300;
   localparam int HOLD_CYCLES   = 64;
   localparam int PHASES        = 4;
   localparam int PHASE_ITEMS   = 270;
   localparam int DIR_ROWS      = 25;
   localparam int NO_CFG        = -1;
   localparam longint PREDICT   = -1;
   localparam int MAX_REPORTS   = 10;

   // counter numbers as query indexes
   localparam logic [rfs_pkg::QIDX_W-1:0] IDX_READS  = rfs_pkg::QIDX_W'(rfs_pkg::EV_READS);
   localparam logic [rfs_pkg::QIDX_W-1:0] IDX_BOTH   = rfs_pkg::QIDX_W'(rfs_pkg::EV_BOTH);
   localparam logic [rfs_pkg::QIDX_W-1:0] IDX_SINGLE = rfs_pkg::QIDX_W'(rfs_pkg::EV_SINGLE);
   localparam logic [rfs_pkg::QIDX_W-1:0] IDX_PROPER = rfs_pkg::QIDX_W'(rfs_pkg::EV_PROPER);
   localparam logic [rfs_pkg::QIDX_W-1:0] IDX_SUM    =
      rfs_pkg::QIDX_W'(rfs_pkg::SEL_INSERT_SUM);
   localparam logic [rfs_pkg::QIDX_W-1:0] IDX_COUNT  =
      rfs_pkg::QIDX_W'(rfs_pkg::SEL_INSERT_COUNT);

   localparam logic [rfs_pkg::QIDX_W-1:0] FIRST_BAD_SEL = IDX_COUNT + 1'b1;
   localparam logic [rfs_pkg::QIDX_W-1:0] LAST_BIN      = rfs_pkg::QIDX_W'(BINS - 1);

   // one request item
   typedef struct {
      rfs_pkg::op_type                     op;
      logic [rfs_pkg::FLAG_W-1:0]          flags;
      logic [rfs_pkg::LEN_W-1:0]           len;
      logic signed [rfs_pkg::INSERT_W-1:0] ins;
      logic [rfs_pkg::QIDX_W-1:0]          idx;
   } read_req_type;

   // directed row: item, optional insert_enable write before it, and a
   // typed result where one is obvious (PREDICT otherwise)
   typedef struct {
      rfs_pkg::op_type                     op;
      logic [rfs_pkg::FLAG_W-1:0]          flags;
      logic [rfs_pkg::LEN_W-1:0]           len;
      logic signed [rfs_pkg::INSERT_W-1:0] ins;
      logic [rfs_pkg::QIDX_W-1:0]          idx;
      int                                  cfg;
      longint                              want_value;
      bit                                  want_bad;
   } dir_row_type;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [1:0]                 req_type;
   logic [10:0]                req_flag_word;
   logic [15:0]                req_read_length;
   logic signed [31:0]         req_insert_size;
   logic [9:0]                 req_query_index;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic [47:0]                rsp_value;
   logic                       rsp_index_bad;
   logic                       csr_write_enable;
   logic                       csr_write_data;

   // local copy of the block state
   logic [CW-1:0]                  stat_events [rfs_pkg::NUM_EVENTS];
   logic [rfs_pkg::SUM_W-1:0]      stat_ins_sum;
   logic [CW-1:0]                  stat_ins_count;
   logic [rfs_pkg::BIN_DATA_W-1:0] stat_len_hist [BINS];
   bit                             stat_ins_enable;

   rfs_pkg::rsp_type           awaited_stats [$];
   int                         mismatch_count = 0;
   int                         items_sent = 0;
   int                         results_seen = 0;
   bit                         quiet = 1'b0;
   int                         hold_left = 0;
   bit                         held_off = 1'b0;

   dir_row_type directed_rows [DIR_ROWS] = '{
      // reset values, bad counter numbers, unused request type
      '{rfs_pkg::OP_COUNTER, 11'h000, 16'd0,    32'sd0,  IDX_READS,     NO_CFG, 0, 1'b0},
      '{rfs_pkg::OP_BIN,     11'h000, 16'd0,    32'sd0,  LAST_BIN,      NO_CFG, 0, 1'b0},
      '{rfs_pkg::OP_COUNTER, 11'h000, 16'd0,    32'sd0,  FIRST_BAD_SEL, NO_CFG, 0, 1'b1},
      '{rfs_pkg::OP_COUNTER, 11'h7FF, 16'hFFFF, -32'sd1, 10'h3FF,       NO_CFG, 0, 1'b1},
      '{rfs_pkg::OP_NONE,    11'h7FF, 16'hFFFF, -32'sd1, 10'h3FF,       NO_CFG, 0, 1'b0},
      // records with insert accumulation off
      '{rfs_pkg::OP_RECORD,  11'h000, 16'd0,    32'sd0,  10'd0,         NO_CFG, 1, 1'b0},
      '{rfs_pkg::OP_RECORD,  11'h7FF, 16'hFFFF, 32'sh80000000, 10'h3FF, NO_CFG, 2, 1'b0},
      '{rfs_pkg::OP_COUNTER, 11'h000, 16'd0,    32'sd0,  IDX_COUNT,     NO_CFG, 0, 1'b0},
      // insert accumulation on: most negative insert, largest positive
      '{rfs_pkg::OP_RECORD,  11'h041, 16'd1023, 32'sh80000000, 10'd0,   1,      3, 1'b0},
      '{rfs_pkg::OP_RECORD,  11'h0C3, 16'd1024, 32'sh7FFFFFFF, 10'd0,   NO_CFG, 4, 1'b0},
      // mate unmapped, negative insert
      '{rfs_pkg::OP_RECORD,  11'h049, 16'd5,    -32'sd100, 10'd0,       NO_CFG, 5, 1'b0},
      // unmapped read, zero insert is not counted
      '{rfs_pkg::OP_RECORD,  11'h04D, 16'd5,    32'sd0,  10'd0,         NO_CFG, 6, 1'b0},
      // second mate only, reverse
      '{rfs_pkg::OP_RECORD,  11'h095, 16'd2,    32'sd500, 10'd0,        NO_CFG, 7, 1'b0},
      // first bit without paired: pair bits ignored
      '{rfs_pkg::OP_RECORD,  11'h040, 16'd1,    32'sd77, 10'd0,         NO_CFG, 8, 1'b0},
      // failed QC and duplicate
      '{rfs_pkg::OP_RECORD,  11'h600, 16'd0,    32'sd0,  10'd0,         NO_CFG, 9, 1'b0},
      '{rfs_pkg::OP_COUNTER, 11'h000, 16'd0,    32'sd0,  IDX_SUM,     NO_CFG, PREDICT, 1'b0},
      '{rfs_pkg::OP_COUNTER, 11'h000, 16'd0,    32'sd0,  IDX_COUNT,   NO_CFG, PREDICT, 1'b0},
      '{rfs_pkg::OP_COUNTER, 11'h000, 16'd0,    32'sd0,  IDX_BOTH,    NO_CFG, PREDICT, 1'b0},
      '{rfs_pkg::OP_COUNTER, 11'h000, 16'd0,    32'sd0,  IDX_SINGLE,  NO_CFG, PREDICT, 1'b0},
      '{rfs_pkg::OP_COUNTER, 11'h000, 16'd0,    32'sd0,  IDX_PROPER,  NO_CFG, PREDICT, 1'b0},
      '{rfs_pkg::OP_BIN,     11'h000, 16'd0,    32'sd0,  LAST_BIN,    NO_CFG, PREDICT, 1'b0},
      '{rfs_pkg::OP_BIN,     11'h000, 16'd0,    32'sd0,  10'd5,       NO_CFG, PREDICT, 1'b0},
      '{rfs_pkg::OP_BIN,     11'h000, 16'd0,    32'sd0,  10'd0,       NO_CFG, PREDICT, 1'b0},
      // accumulation off again: paired first mate adds nothing
      '{rfs_pkg::OP_RECORD,  11'h041, 16'd7,    32'sd12345, 10'd0,      0,      10, 1'b0},
      '{rfs_pkg::OP_COUNTER, 11'h000, 16'd0,    32'sd0,  IDX_COUNT,   NO_CFG, PREDICT, 1'b0}
   };

   read_flag_statistics dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_type         (req_type),
      .req_flag_word    (req_flag_word),
      .req_read_length  (req_read_length),
      .req_insert_size  (req_insert_size),
      .req_query_index  (req_query_index),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_value        (rsp_value),
      .rsp_index_bad    (rsp_index_bad),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // saturating event counter bump
   function automatic void bump_event(input int k);
      if (stat_events[k] != '1) stat_events[k] = stat_events[k] + 1'b1;
   endfunction

   // apply one item to the local state and return its result
   function automatic rfs_pkg::rsp_type apply_read_item(input read_req_type r);
      rfs_pkg::rsp_type               res;
      logic [rfs_pkg::INSERT_W-1:0]   mag;
      logic [rfs_pkg::SUM_W:0]        grown;
      int                             bin;
      res.value     = '0;
      res.index_bad = 1'b0;
      case (r.op)
         rfs_pkg::OP_RECORD: begin
            bump_event(rfs_pkg::EV_READS);
            if (r.flags[rfs_pkg::FL_DUP]) bump_event(rfs_pkg::EV_DUP);
            if (r.flags[rfs_pkg::FL_QCFAIL]) bump_event(rfs_pkg::EV_QCFAIL);
            if (!r.flags[rfs_pkg::FL_UNMAPPED]) bump_event(rfs_pkg::EV_MAPPED);
            if (r.flags[rfs_pkg::FL_REVERSE]) bump_event(rfs_pkg::EV_REVERSE);
            else bump_event(rfs_pkg::EV_FORWARD);
            // pair bits only count on paired reads
            if (r.flags[rfs_pkg::FL_PAIRED]) begin
               bump_event(rfs_pkg::EV_PAIRED);
               if (r.flags[rfs_pkg::FL_FIRST]) bump_event(rfs_pkg::EV_FIRST);
               if (r.flags[rfs_pkg::FL_SECOND]) bump_event(rfs_pkg::EV_SECOND);
               if (!r.flags[rfs_pkg::FL_UNMAPPED]) begin
                  if (!r.flags[rfs_pkg::FL_MATE_UNMAPPED]) bump_event(rfs_pkg::EV_BOTH);
                  else bump_event(rfs_pkg::EV_SINGLE);
               end
               if (r.flags[rfs_pkg::FL_PROPER]) bump_event(rfs_pkg::EV_PROPER);
               if (stat_ins_enable && r.flags[rfs_pkg::FL_FIRST] && r.ins != 0) begin
                  // unsigned negate: most negative insert gives 2^31
                  mag = r.ins[rfs_pkg::INSERT_W-1] ? (~r.ins + 1'b1) : r.ins;
                  grown = {1'b0, stat_ins_sum} + (rfs_pkg::SUM_W + 1)'(mag);
                  stat_ins_sum = grown[rfs_pkg::SUM_W] ? '1 : grown[rfs_pkg::SUM_W-1:0];
                  if (stat_ins_count != '1) stat_ins_count = stat_ins_count + 1'b1;
               end
            end
            bin = (int'(r.len) >= BINS - 1) ? BINS - 1 : int'(r.len);
            if (stat_len_hist[bin] != '1) stat_len_hist[bin] = stat_len_hist[bin] + 1'b1;
            res.value = rfs_pkg::VALUE_W'(stat_events[rfs_pkg::EV_READS]);
         end
         rfs_pkg::OP_COUNTER: begin
            if (r.idx < rfs_pkg::NUM_EVENTS)
               res.value = rfs_pkg::VALUE_W'(stat_events[r.idx]);
            else if (r.idx == IDX_SUM) res.value = stat_ins_sum;
            else if (r.idx == IDX_COUNT) res.value = rfs_pkg::VALUE_W'(stat_ins_count);
            else res.index_bad = 1'b1;
         end
         // a 10-bit index never passes the last of 1024 bins
         rfs_pkg::OP_BIN: res.value = rfs_pkg::VALUE_W'(stat_len_hist[r.idx]);
         default: ;
      endcase
      return res;
   endfunction

   task automatic note_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS) $display("%0t ns: %s", $time, msg);
   endtask

   // offer one item with random idle cycles ahead of it, then queue its result
   task automatic offer_item(input read_req_type r, input longint want_value,
                             input bit want_bad);
      rfs_pkg::rsp_type guess;
      quiet = (items_sent >= QUIET_FROM && items_sent < QUIET_TO);
      while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= r.op;
      req_flag_word   <= r.flags;
      req_read_length <= r.len;
      req_insert_size <= r.ins;
      req_query_index <= r.idx;
      do @(posedge clock); while (req_stall);
      items_sent++;
      guess = apply_read_item(r);
      if (want_value != PREDICT) begin
         guess.value     = rfs_pkg::VALUE_W'(want_value);
         guess.index_bad = want_bad;
      end
      awaited_stats = {awaited_stats, guess};
   endtask

   // write insert_enable once the block has drained
   task automatic set_insert_enable(input bit on);
      req_valid <= 1'b0;
      while (awaited_stats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= on;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      stat_ins_enable = on;
   endtask

   // result side: check each accepted item, then pick next cycle's stall
   always @(posedge clock) begin : rsp_side
      rfs_pkg::rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (awaited_stats.size() == 0) begin
               note_mismatch($sformatf("unexpected result value=%0h index_bad=%0b",
                                       rsp_value, rsp_index_bad));
            end else begin
               want = awaited_stats.pop_front();
               if (rsp_value !== want.value)
                  note_mismatch($sformatf("value: expected %0h, got %0h",
                                          want.value, rsp_value));
               if (rsp_index_bad !== want.index_bad)
                  note_mismatch($sformatf("index_bad: expected %0b, got %0b",
                                          want.index_bad, rsp_index_bad));
            end
         end
         // one long hold so the request side backs up and stalls
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if (!held_off && results_seen >= HOLD_AT) begin
            held_off  <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
         end
      end
   end

   // stimulus
   initial begin
      read_req_type r;
      int           pick;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_type         <= rfs_pkg::OP_RECORD;
      req_flag_word    <= '0;
      req_read_length  <= '0;
      req_insert_size  <= '0;
      req_query_index  <= '0;
      csr_write_enable <= 1'b0;
      csr_write_data   <= 1'b0;
      foreach (stat_events[i]) stat_events[i] = '0;
      foreach (stat_len_hist[i]) stat_len_hist[i] = '0;
      stat_ins_sum    = '0;
      stat_ins_count  = '0;
      stat_ins_enable = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[i]) begin
         if (directed_rows[i].cfg != NO_CFG) set_insert_enable(directed_rows[i].cfg[0]);
         r.op    = directed_rows[i].op;
         r.flags = directed_rows[i].flags;
         r.len   = directed_rows[i].len;
         r.ins   = directed_rows[i].ins;
         r.idx   = directed_rows[i].idx;
         offer_item(r, directed_rows[i].want_value, directed_rows[i].want_bad);
      end

      // random phases, insert accumulation alternating on and off
      for (int ph = 0; ph < PHASES; ph++) begin
         set_insert_enable(!ph[0]);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick    = $urandom_range(0, 99);
            r.op    = (pick < 55) ? rfs_pkg::OP_RECORD : (pick < 80) ? rfs_pkg::OP_COUNTER :
                      (pick < 95) ? rfs_pkg::OP_BIN : rfs_pkg::OP_NONE;
            r.flags = rfs_pkg::FLAG_W'($urandom);
            if ($urandom_range(0, 1) != 0) begin
               r.flags[rfs_pkg::FL_PAIRED] = 1'b1;
               r.flags[rfs_pkg::FL_FIRST]  = 1'b1;
            end
            case ($urandom_range(0, 9))
               0:       r.len = rfs_pkg::LEN_W'($urandom);
               1:       r.len = rfs_pkg::LEN_W'($urandom_range(BINS - 4, BINS + 6));
               default: r.len = rfs_pkg::LEN_W'($urandom_range(0, 40));
            endcase
            case ($urandom_range(0, 9))
               0:       r.ins = '0;
               1:       r.ins = 32'sh80000000;
               2, 3:    r.ins = rfs_pkg::INSERT_W'($urandom);
               default: r.ins = rfs_pkg::INSERT_W'($urandom_range(0, 2000)) - 32'sd1000;
            endcase
            if (r.op == rfs_pkg::OP_COUNTER) begin
               r.idx = ($urandom_range(0, 9) != 0) ?
                       rfs_pkg::QIDX_W'($urandom_range(0, IDX_COUNT)) :
                       rfs_pkg::QIDX_W'($urandom);
            end else begin
               case ($urandom_range(0, 19))
                  0, 1, 2: r.idx = rfs_pkg::QIDX_W'($urandom_range(BINS - 4, BINS - 1));
                  3, 4, 5: r.idx = rfs_pkg::QIDX_W'($urandom);
                  default: r.idx = rfs_pkg::QIDX_W'($urandom_range(0, 40));
               endcase
            end
            offer_item(r, PREDICT, 1'b0);
         end
      end

      // drain, then allow the pipeline to show any stray result
      req_valid <= 1'b0;
      while (awaited_stats.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // run limit: far beyond the clearing pass plus the slowest correct run
   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

>>> files.f
+incdir+rtl
rtl/rfs_pkg.sv
rtl/rfs_queue.sv
rtl/rfs_front.sv
rtl/rfs_back.sv
rtl/read_flag_statistics.sv
rtl/rfs_checker.sv
verif/tb_read_flag_statistics.sv
